// ===== rtl/rmf_pkg.sv =====
// ----------------------------------------------------------------------------
// Row median filter package
// Shared pixel type, configuration constants and control structures.
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int PIXEL_W = 8;
  localparam int CFG_W   = 3;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [CFG_W-1:0]   half_width_t;

  localparam half_width_t HALF_WIDTH_RESET = half_width_t'(1);

  // Commands from the sequencer to the window.
  typedef struct packed {
    logic shift;
    logic flush;
    logic clear;
    logic step;
  } rmf_win_ctrl_t;

  // Commands and broadcast sample from the window to every cell.
  typedef struct packed {
    logic   shift;
    logic   flush;
    logic   clear;
    logic   step;
    logic   bc_valid;
    pixel_t bc_sample;
  } rmf_cell_ctrl_t;

endpackage

// ===== rtl/rmf_pix_if.sv =====
// ----------------------------------------------------------------------------
// Row median filter pixel channel
// Valid/ready channel carrying one raster pixel and its end-of-row mark.
// ----------------------------------------------------------------------------
interface rmf_pix_if
  import rmf_pkg::*;
  ();

  logic   valid;
  logic   ready;
  pixel_t pixel_in;
  logic   row_end_in;

  modport source (output valid, output pixel_in, output row_end_in, input ready);
  modport sink   (input valid, input pixel_in, input row_end_in, output ready);

endinterface

// ===== rtl/rmf_res_if.sv =====
// ----------------------------------------------------------------------------
// Row median filter result channel
// Valid/ready channel carrying one filtered pixel and its marks.
// ----------------------------------------------------------------------------
interface rmf_res_if
  import rmf_pkg::*;
  ();

  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   row_end_out;
  logic   last_of_run;

  modport source (
    output valid, output pixel_out, output row_end_out, output last_of_run,
    input ready
  );
  modport sink (
    input valid, input pixel_out, input row_end_out, input last_of_run,
    output ready
  );

endinterface

// ===== rtl/rmf_cell.sv =====
// ----------------------------------------------------------------------------
// Row median filter window cell
// Holds one window sample and its valid mark, shifts them on to the next
// cell and counts the rank of its sample against the broadcast samples.
// ----------------------------------------------------------------------------
module rmf_cell
  import rmf_pkg::*;
#(
  parameter int RANK_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rmf_cell_ctrl_t    ctrl_i,
  input  logic              tie_i,
  input  pixel_t            prev_sample_i,
  input  logic              prev_valid_i,
  output pixel_t            sample_o,
  output logic              valid_o,
  output logic [RANK_W-1:0] rank_o
);

  pixel_t            sample_q;
  logic              valid_q;
  logic [RANK_W-1:0] rank_q;
  logic              below;

  // A broadcast sample ranks below this one if it is smaller, or equal and
  // held in a newer slot, so that the ranks form a strict order.
  assign below = ctrl_i.bc_valid &&
                 ((ctrl_i.bc_sample < sample_q) ||
                  ((ctrl_i.bc_sample == sample_q) && tie_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.flush) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      sample_q <= prev_sample_i;
    end
    if (ctrl_i.clear) begin
      rank_q <= '0;
    end else if (ctrl_i.step && below) begin
      rank_q <= rank_q + RANK_W'(1);
    end
  end

  assign sample_o = sample_q;
  assign valid_o  = valid_q;
  assign rank_o   = rank_q;

endmodule

// ===== rtl/rmf_window.sv =====
// ----------------------------------------------------------------------------
// Row median filter window
// Chain of cells holding the newest samples of the row, with the broadcast
// of one sample per cycle and the selection of the median by rank.
// ----------------------------------------------------------------------------
module rmf_window
  import rmf_pkg::*;
#(
  parameter int SLOTS = 15
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rmf_win_ctrl_t              ctrl_i,
  input  pixel_t                     pixel_i,
  input  logic [$clog2(SLOTS)-1:0]   k_i,
  input  logic [$clog2(SLOTS)-1:0]   lo_i,
  input  logic [$clog2(SLOTS)-1:0]   hi_i,
  output pixel_t                     median_o
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  pixel_t            sample  [SLOTS];
  logic              valid   [SLOTS];
  logic [IDX_W-1:0]  rank    [SLOTS];
  logic              sel     [SLOTS];
  rmf_cell_ctrl_t    cell_ctrl;
  logic [CNT_W-1:0]  count_q;
  logic [IDX_W-1:0]  mid;

  always_comb begin
    cell_ctrl.shift     = ctrl_i.shift;
    cell_ctrl.flush     = ctrl_i.flush;
    cell_ctrl.clear     = ctrl_i.clear;
    cell_ctrl.step      = ctrl_i.step;
    cell_ctrl.bc_valid  = valid[k_i];
    cell_ctrl.bc_sample = sample[k_i];
  end

  for (genvar j = 0; j < SLOTS; j++) begin : g_cell
    pixel_t prev_sample;
    logic   prev_valid;

    if (j == 0) begin : g_head
      assign prev_sample = pixel_i;
      assign prev_valid  = 1'b1;
    end else begin : g_link
      assign prev_sample = sample[j-1];
      assign prev_valid  = valid[j-1];
    end

    rmf_cell #(
      .RANK_W(IDX_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .tie_i        (k_i < IDX_W'(j)),
      .prev_sample_i(prev_sample),
      .prev_valid_i (prev_valid),
      .sample_o     (sample[j]),
      .valid_o      (valid[j]),
      .rank_o       (rank[j])
    );

    assign sel[j] = valid[j] && (IDX_W'(j) >= lo_i) && (IDX_W'(j) <= hi_i) &&
                    (rank[j] == mid);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.clear) begin
      count_q <= '0;
    end else if (ctrl_i.step && cell_ctrl.bc_valid) begin
      count_q <= count_q + CNT_W'(1);
    end
  end

  assign mid = IDX_W'(count_q >> 1);

  always_comb begin
    median_o = '0;
    for (int j = 0; j < SLOTS; j++) begin
      if (sel[j]) begin
        median_o = median_o | sample[j];
      end
    end
  end

endmodule

// ===== rtl/row_median_filter.sv =====
// ----------------------------------------------------------------------------
// Row median filter
// Horizontal median over 8-bit grey pixels, truncated at both row ends.
//
// Pixels enter on pix_i in raster order, row_end_in marking the last pixel of
// a row. Filtered pixels leave on res_o; row_end_out marks the last pixel of
// the row and last_of_run the final result caused by one input transfer.
// The half width is written through cfg_we_i/cfg_wdata_i and is saturated to
// MAX_HALF_WIDTH; the user must write it only while the block is idle, which
// the block itself does not enforce. One pixel is taken at a time. Output lags
// input by the half width h; at a row end all pending pixels are produced. An
// input transfer that causes no result leaves the block idle. Otherwise each
// result is formed over the s <= 2h + 1 window slots from max(c - h, 0) to
// c + h around its centre c: the cells rank their samples against one
// broadcast slot per cycle, then the median is registered.
// At reset the window is empty, no pixel is pending and the half width is 1.
// A result waits in the output register while the receiver stalls; the next
// result of the run waits for it to be taken. Once the last result of a run
// is registered, a new input transfer may occur.
// ----------------------------------------------------------------------------
module row_median_filter
  import rmf_pkg::*;
#(
  parameter int MAX_HALF_WIDTH = 7
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  half_width_t  cfg_wdata_i,
  rmf_pix_if.sink      pix_i,
  rmf_res_if.source    res_o
);

  localparam int SLOTS = 2 * MAX_HALF_WIDTH + 1;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int EXT_W = (IDX_W > CFG_W) ? IDX_W + 1 : CFG_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_EMIT} state_e;

  state_e            state_q;
  half_width_t       half_width_q;
  logic [CNT_W-1:0]  lead_q;
  logic [IDX_W-1:0]  h_q;
  logic              row_end_q;
  logic [IDX_W-1:0]  c_q;
  logic [IDX_W-1:0]  last_c_q;
  logic [IDX_W-1:0]  k_q;
  logic [IDX_W-1:0]  lo_q;
  logic [IDX_W-1:0]  hi_q;
  logic              res_valid_q;
  pixel_t            res_pixel_q;
  logic              res_row_end_q;
  logic              res_last_q;

  logic [EXT_W-1:0]  hw_ext;
  logic [IDX_W-1:0]  h_eff;
  logic [CNT_W:0]    lead_inc;
  logic [CNT_W-1:0]  pending;
  logic              has_out;
  logic [IDX_W-1:0]  c_first;
  logic [CNT_W-1:0]  lead_new;
  logic [IDX_W-1:0]  c_next;
  logic [IDX_W-1:0]  c_sel;
  logic [IDX_W-1:0]  h_sel;
  logic [IDX_W:0]    hi_sum;
  logic [IDX_W-1:0]  lo_sel;
  logic [IDX_W-1:0]  hi_sel;
  logic              accept;
  logic              out_free;
  logic              emit;
  logic              last_c;
  rmf_win_ctrl_t     win_ctrl;
  pixel_t            median;

  always_comb begin
    hw_ext   = EXT_W'(half_width_q);
    h_eff    = (hw_ext > EXT_W'(MAX_HALF_WIDTH)) ? IDX_W'(MAX_HALF_WIDTH)
                                                 : IDX_W'(hw_ext);
    lead_inc = {1'b0, lead_q} + (CNT_W + 1)'(1);
    pending  = (lead_inc > (CNT_W + 1)'(SLOTS)) ? CNT_W'(SLOTS)
                                                : lead_inc[CNT_W-1:0];
    has_out  = pix_i.row_end_in || (pending > CNT_W'(h_eff));
    c_first  = IDX_W'(pending - CNT_W'(1));
    if (pix_i.row_end_in) begin
      lead_new = '0;
    end else if (pending > CNT_W'(h_eff)) begin
      lead_new = CNT_W'(h_eff);
    end else begin
      lead_new = pending;
    end
    c_next = c_q - IDX_W'(1);
    c_sel  = (state_q == S_IDLE) ? c_first : c_next;
    h_sel  = (state_q == S_IDLE) ? h_eff : h_q;
    hi_sum = {1'b0, c_sel} + {1'b0, h_sel};
    hi_sel = (hi_sum > (IDX_W + 1)'(SLOTS - 1)) ? IDX_W'(SLOTS - 1)
                                                : hi_sum[IDX_W-1:0];
    lo_sel = (c_sel > h_sel) ? c_sel - h_sel : '0;
  end

  assign pix_i.ready = (state_q == S_IDLE);
  assign accept      = pix_i.valid && pix_i.ready;
  assign out_free    = !res_valid_q || res_o.ready;
  assign emit        = (state_q == S_EMIT) && out_free;
  assign last_c      = (c_q == last_c_q);

  always_comb begin
    win_ctrl.shift = accept;
    win_ctrl.clear = accept || (emit && !last_c);
    win_ctrl.step  = (state_q == S_SWEEP);
    win_ctrl.flush = emit && last_c && row_end_q;
  end

  rmf_window #(
    .SLOTS(SLOTS)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (win_ctrl),
    .pixel_i (pix_i.pixel_in),
    .k_i     (k_q),
    .lo_i    (lo_q),
    .hi_i    (hi_q),
    .median_o(median)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= HALF_WIDTH_RESET;
    end else if (cfg_we_i) begin
      half_width_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      lead_q        <= '0;
      h_q           <= '0;
      row_end_q     <= 1'b0;
      c_q           <= '0;
      last_c_q      <= '0;
      k_q           <= '0;
      lo_q          <= '0;
      hi_q          <= '0;
      res_valid_q   <= 1'b0;
      res_pixel_q   <= '0;
      res_row_end_q <= 1'b0;
      res_last_q    <= 1'b0;
    end else begin
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            h_q       <= h_eff;
            row_end_q <= pix_i.row_end_in;
            lead_q    <= lead_new;
            if (has_out) begin
              c_q      <= c_first;
              last_c_q <= pix_i.row_end_in ? '0 : h_eff;
              lo_q     <= lo_sel;
              hi_q     <= hi_sel;
              k_q      <= lo_sel;
              state_q  <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          if (k_q == hi_q) begin
            state_q <= S_EMIT;
          end else begin
            k_q <= k_q + IDX_W'(1);
          end
        end
        S_EMIT: begin
          if (out_free) begin
            res_pixel_q   <= median;
            res_row_end_q <= row_end_q && (c_q == '0);
            res_last_q    <= last_c;
            if (last_c) begin
              state_q <= S_IDLE;
            end else begin
              c_q     <= c_next;
              lo_q    <= lo_sel;
              hi_q    <= hi_sel;
              k_q     <= lo_sel;
              state_q <= S_SWEEP;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.pixel_out   = res_pixel_q;
  assign res_o.row_end_out = res_row_end_q;
  assign res_o.last_of_run = res_last_q;

  a_sweep_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SWEEP) |-> (k_q >= lo_q) && (k_q <= hi_q)
  ) else $error("window sweep index left the window bounds");

  a_centre_order: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (c_q >= last_c_q)
  ) else $error("output centre passed the last centre of the run");

  a_row_end_closes_run: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_row_end_q) |-> res_last_q
  ) else $error("row end result is not the last result of its run");

  a_lead_bounded: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (lead_q <= CNT_W'(MAX_HALF_WIDTH))
  ) else $error("more pixels pending than the widest window allows");

  a_flush_empties_lead: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    win_ctrl.flush |-> (lead_q == '0)
  ) else $error("row end flush with pixels still counted as pending");

endmodule
